// ===== design/telnet_command_filter_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef TELNET_COMMAND_FILTER_DEFINES_SVH
`define TELNET_COMMAND_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcf assertion failed");

`endif

// ===== design/tcf_pkg.sv =====
package tcf_pkg;

	localparam logic [7:0] IAC       = 8'hff;
	localparam logic [7:0] CMD_WILL  = 8'd251;
	localparam logic [7:0] CMD_WONT  = 8'd252;
	localparam logic [7:0] CMD_DO    = 8'd253;
	localparam logic [7:0] CMD_DONT  = 8'd254;
	localparam logic [7:0] CMD_SB    = 8'd250;
	localparam logic [7:0] CMD_SE    = 8'd240;
	localparam logic [7:0] OPT_ECHO  = 8'd1;
	localparam logic [7:0] OPT_SGA   = 8'd3;
	localparam logic [7:0] OPT_TTYPE = 8'd24;
	localparam logic [7:0] OPT_NAWS  = 8'd31;
	localparam logic [7:0] SUB_IS    = 8'd0;

	localparam logic [1:0] HELD_FULL = 2'd3;

	localparam int MAX_TERM_CHARS_DEF = 8;

	// register indexes on the write port
	localparam logic [2:0] REG_PASSTHROUGH = 3'd0;
	localparam logic [2:0] REG_COLUMNS     = 3'd1;
	localparam logic [2:0] REG_ROWS        = 3'd2;
	localparam logic [2:0] REG_TTYPE_CHARS = 3'd3;
	localparam logic [2:0] REG_TTYPE_LEN   = 3'd4;

	localparam logic [15:0] COLUMNS_RST = 16'd80;
	localparam logic [15:0] ROWS_RST    = 16'd24;

	typedef enum logic [1:0] {
		RK_PASS,
		RK_WILL,
		RK_DO,
		RK_TTYPE
	} reply_kind_t;

	// one pending run of results: kind, its byte (data or option), index of last result
	typedef struct packed {
		reply_kind_t kind;
		logic [7:0]  data;
		logic [3:0]  last_idx;
	} reply_t;

endpackage

// ===== design/tcf_reply.sv =====
module tcf_reply (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rep_valid,
	input  tcf_pkg::reply_t  rep,
	output logic             rep_done,
	input  logic [15:0]      page_columns,
	input  logic [15:0]      page_rows,
	input  logic [63:0]      term_type_chars,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             destination,
	output logic [7:0]       out_byte,
	output logic             last_of_run
);

	logic [3:0] idx_q;
	logic       out_valid_q;
	logic       dest_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic       move;
	logic       is_last;
	logic       dest_d;
	logic [7:0] byte_d;
	logic [3:0] char_idx;
	logic [7:0] name_char;

	assign move     = !out_valid_q || out_ready;
	assign is_last  = (idx_q == rep.last_idx);
	assign rep_done = rep_valid && move && is_last;

	assign char_idx  = idx_q - 4'd4;
	assign name_char = term_type_chars[{char_idx[2:0], 3'b000} +: 8];

	always_comb begin
		dest_d = 1'b1;
		byte_d = tcf_pkg::IAC;
		case (rep.kind)
			tcf_pkg::RK_PASS: begin
				dest_d = 1'b0;
				byte_d = rep.data;
			end
			tcf_pkg::RK_WILL: begin
				case (idx_q)
					4'd0: byte_d = tcf_pkg::IAC;
					4'd1: byte_d = (rep.data == tcf_pkg::OPT_ECHO || rep.data == tcf_pkg::OPT_SGA)
						? tcf_pkg::CMD_DO : tcf_pkg::CMD_DONT;
					default: byte_d = rep.data;
				endcase
			end
			tcf_pkg::RK_DO: begin
				case (idx_q)
					4'd0: byte_d = tcf_pkg::IAC;
					4'd1: byte_d = (rep.data == tcf_pkg::OPT_TTYPE || rep.data == tcf_pkg::OPT_NAWS)
						? tcf_pkg::CMD_WILL : tcf_pkg::CMD_WONT;
					4'd2: byte_d = rep.data;
					4'd3: byte_d = tcf_pkg::IAC;
					4'd4: byte_d = tcf_pkg::CMD_SB;
					4'd5: byte_d = tcf_pkg::OPT_NAWS;
					4'd6: byte_d = page_columns[15:8];
					4'd7: byte_d = page_columns[7:0];
					4'd8: byte_d = page_rows[15:8];
					4'd9: byte_d = page_rows[7:0];
					4'd10: byte_d = tcf_pkg::IAC;
					default: byte_d = tcf_pkg::CMD_SE;
				endcase
			end
			default: begin
				// terminal-type: IAC SB 24 IS <name> IAC SE
				if (is_last) begin
					byte_d = tcf_pkg::CMD_SE;
				end else if (idx_q == rep.last_idx - 4'd1) begin
					byte_d = tcf_pkg::IAC;
				end else begin
					case (idx_q)
						4'd0: byte_d = tcf_pkg::IAC;
						4'd1: byte_d = tcf_pkg::CMD_SB;
						4'd2: byte_d = tcf_pkg::OPT_TTYPE;
						4'd3: byte_d = tcf_pkg::SUB_IS;
						default: byte_d = name_char;
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= rep_valid;
			if (rep_valid) begin
				idx_q <= is_last ? 4'd0 : idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move && rep_valid) begin
			dest_q <= dest_d;
			byte_q <= byte_d;
			last_q <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign destination = dest_q;
	assign out_byte    = byte_q;
	assign last_of_run = last_q;

endmodule

// ===== design/telnet_command_filter.sv =====
// An accepted item is registered in the reply stage, and each of its results then in
// the output register. Throughput: one result per cycle while out_ready is high; a
// reply run of up to 14 results holds the reply stage, set by the result counter.
// Items that only advance command state produce nothing and do not fill the reply stage.
// Reset (arst_n low, asynchronous) clears command state and empties both stages;
// registers return to passthrough off, 80 columns, 24 rows, empty terminal name.
module telnet_command_filter #(
	parameter int MAX_TERM_CHARS = tcf_pkg::MAX_TERM_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [63:0] wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        destination,
	output logic [7:0]  out_byte,
	output logic        last_of_run
);

	logic        passthrough_q;
	logic [15:0] columns_q;
	logic [15:0] rows_q;
	logic [63:0] ttype_chars_q;
	logic [3:0]  ttype_len_q;

	logic        in_cmd_q;
	logic [7:0]  cmd_q;
	logic [7:0]  opt_q;
	logic [1:0]  held_q;

	logic            rep_valid_s1;
	tcf_pkg::reply_t rep_s1;

	logic            in_fire;
	logic            rep_done;
	logic            emit_d;
	tcf_pkg::reply_t rep_d;
	logic            n_in_cmd;
	logic [7:0]      n_cmd;
	logic [7:0]      n_opt;
	logic [1:0]      n_held;
	logic [7:0]      cmd_w;
	logic [7:0]      opt_w;
	logic [1:0]      held_w;
	logic            close;
	logic [3:0]      name_len;

	assign in_ready = !rep_valid_s1 || rep_done;
	assign in_fire  = in_valid && in_ready;

	assign name_len = (ttype_len_q > 4'(MAX_TERM_CHARS)) ? 4'(MAX_TERM_CHARS) : ttype_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			passthrough_q <= 1'b0;
			columns_q     <= tcf_pkg::COLUMNS_RST;
			rows_q        <= tcf_pkg::ROWS_RST;
			ttype_chars_q <= '0;
			ttype_len_q   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				tcf_pkg::REG_PASSTHROUGH: passthrough_q <= wr_data[0];
				tcf_pkg::REG_COLUMNS:     columns_q     <= wr_data[15:0];
				tcf_pkg::REG_ROWS:        rows_q        <= wr_data[15:0];
				tcf_pkg::REG_TTYPE_CHARS: ttype_chars_q <= wr_data;
				tcf_pkg::REG_TTYPE_LEN:   ttype_len_q   <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		n_in_cmd = in_cmd_q;
		n_cmd    = cmd_q;
		n_opt    = opt_q;
		n_held   = held_q;
		emit_d   = 1'b0;
		close    = 1'b0;
		rep_d    = '{kind: tcf_pkg::RK_PASS, data: rx_byte, last_idx: 4'd0};
		cmd_w    = (held_q == 2'd1) ? rx_byte : cmd_q;
		opt_w    = (held_q == 2'd2) ? rx_byte : opt_q;
		held_w   = (held_q == tcf_pkg::HELD_FULL) ? held_q : held_q + 2'd1;
		if (passthrough_q) begin
			emit_d = 1'b1;
		end else if (in_cmd_q) begin
			n_cmd  = cmd_w;
			n_opt  = opt_w;
			n_held = held_w;
			case (cmd_w)
				tcf_pkg::CMD_WILL: begin
					if (held_w == tcf_pkg::HELD_FULL) begin
						close  = 1'b1;
						emit_d = 1'b1;
						rep_d  = '{kind: tcf_pkg::RK_WILL, data: opt_w, last_idx: 4'd2};
					end
				end
				tcf_pkg::CMD_DO: begin
					if (held_w == tcf_pkg::HELD_FULL) begin
						close  = 1'b1;
						emit_d = 1'b1;
						rep_d  = '{kind: tcf_pkg::RK_DO, data: opt_w,
							last_idx: (opt_w == tcf_pkg::OPT_NAWS) ? 4'd11 : 4'd2};
					end
				end
				tcf_pkg::CMD_WONT, tcf_pkg::CMD_DONT: begin
					close = (held_w == tcf_pkg::HELD_FULL);
				end
				tcf_pkg::CMD_SB: begin
					if (rx_byte == tcf_pkg::CMD_SE) begin
						close = 1'b1;
						if (opt_w == tcf_pkg::OPT_TTYPE) begin
							emit_d = 1'b1;
							rep_d  = '{kind: tcf_pkg::RK_TTYPE, data: opt_w,
								last_idx: 4'd5 + name_len};
						end
					end
				end
				default: close = 1'b1;
			endcase
			if (close) begin
				n_in_cmd = 1'b0;
				n_cmd    = '0;
				n_opt    = '0;
				n_held   = '0;
			end
		end else if (rx_byte == tcf_pkg::IAC) begin
			n_in_cmd = 1'b1;
			n_cmd    = '0;
			n_opt    = '0;
			n_held   = 2'd1;
		end else begin
			emit_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cmd_q     <= 1'b0;
			cmd_q        <= '0;
			opt_q        <= '0;
			held_q       <= '0;
			rep_valid_s1 <= 1'b0;
		end else begin
			if (in_fire) begin
				in_cmd_q <= n_in_cmd;
				cmd_q    <= n_cmd;
				opt_q    <= n_opt;
				held_q   <= n_held;
			end
			if (in_fire) begin
				rep_valid_s1 <= emit_d;
			end else if (rep_done) begin
				rep_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit_d) begin
			rep_s1 <= rep_d;
		end
	end

	tcf_reply u_reply (
		.clk             (clk),
		.arst_n          (arst_n),
		.rep_valid       (rep_valid_s1),
		.rep             (rep_s1),
		.rep_done        (rep_done),
		.page_columns    (columns_q),
		.page_rows       (rows_q),
		.term_type_chars (ttype_chars_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.destination     (destination),
		.out_byte        (out_byte),
		.last_of_run     (last_of_run)
	);

endmodule

// ===== design/tcf_checker.sv =====
`include "telnet_command_filter_defines.svh"

module tcf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        destination,
	input logic [7:0]  out_byte,
	input logic        last_of_run
);

	// a stalled result holds
	`TCF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(destination) && $stable(last_of_run))

	// terminal bytes are always single-result runs
	`TCF_ASSERT_NOW(a_term_single, clk, arst_n, out_valid && !destination, last_of_run)

	// only network replies span several results
	`TCF_ASSERT_NOW(a_multi_is_net, clk, arst_n, out_valid && !last_of_run, destination)

	// a reply run streams without gaps once started
	`TCF_ASSERT_NEXT(a_run_no_gap, clk, arst_n, out_valid && out_ready && !last_of_run, out_valid && destination)

	// a stalled run that is not finished keeps the input closed
	`TCF_ASSERT_NOW(a_run_blocks_in, clk, arst_n, out_valid && !out_ready && !last_of_run, !in_ready)

endmodule

bind telnet_command_filter tcf_checker u_tcf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.destination (destination),
	.out_byte    (out_byte),
	.last_of_run (last_of_run)
);
